[hw/rtl/accm_pkg.sv]
`timescale 1ns / 1ps

package accm_pkg;

    localparam int ADDR_W        = 7;
    localparam int WORD_W        = 16;
    localparam int OPC_W         = WORD_W - ADDR_W;
    localparam int MEM_DEPTH_DEF = 128;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 48;

    // Item kinds carried on s_tuser.
    localparam logic [1:0] ITEM_LOAD    = 2'd0;
    localparam logic [1:0] ITEM_STEP    = 2'd1;
    localparam logic [1:0] ITEM_RESTART = 2'd2;

    // Instruction codes, taken from the upper bits of a store word.
    localparam logic [OPC_W-1:0] OP_HLT = OPC_W'(8'h00);
    localparam logic [OPC_W-1:0] OP_LDA = OPC_W'(8'h01);
    localparam logic [OPC_W-1:0] OP_JPA = OPC_W'(8'h02);
    localparam logic [OPC_W-1:0] OP_JPZ = OPC_W'(8'h03);
    localparam logic [OPC_W-1:0] OP_JPP = OPC_W'(8'h04);
    localparam logic [OPC_W-1:0] OP_ADD = OPC_W'(8'h05);
    localparam logic [OPC_W-1:0] OP_SUB = OPC_W'(8'h06);
    localparam logic [OPC_W-1:0] OP_STO = OPC_W'(8'h07);
    localparam logic [OPC_W-1:0] OP_OUT = OPC_W'(8'h08);
    localparam logic [OPC_W-1:0] OP_INP = OPC_W'(8'h09);

    // Result beat, out_valid in the lowest bit.
    typedef struct packed {
        logic [WORD_W-1:0] acc_now;
        logic [ADDR_W-1:0] pc_now;
        logic              halted;
        logic              input_taken;
        logic [WORD_W-1:0] out_value;
        logic              out_valid;
    } res_t;

endpackage

[hw/rtl/accumulator_machine_step.sv]
`timescale 1ns / 1ps

// Channel   Dir  Bus                     Contents
// s_        in   s_tuser[1:0]            operation
//                s_tdata[39:0]           load_address, load_data, input_value
// m_        out  m_tdata[47:0]           out_valid, out_value, input_taken,
//                                        halted, pc_now, acc_now
//
// An execute beat passes through ST_FETCH and ST_EXEC: the single store port
// fetches the instruction at the accept edge and reads or writes the operand
// in ST_FETCH; the result commits from ST_EXEC, when the next beat may
// already be accepted. Load, restart and halted execute beats commit from ST_IMM.
// Reset clears pc, acc, the halt flag and the per-word valid bits at once;
// unwritten words read as zero. A stalled result holds the input off while a beat waits to commit.
module accumulator_machine_step
    import accm_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [6:0] load_address, [22:7] load_data, [38:23] input_value, [39] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] out_valid, [16:1] out_value, [17] input_taken, [18] halted,
    // [25:19] pc_now, [41:26] acc_now, [47:42] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(MEM_DEPTH);
    localparam logic [ADDR_W:0] DEPTH_LIM = (ADDR_W + 1)'(MEM_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_IMM, ST_FETCH, ST_EXEC} state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    pc_reg, pc_next, pc_cmt;
    logic [WORD_W-1:0]    acc_reg, acc_next, acc_cmt;
    logic                 stopped_reg, stopped_next, stopped_cmt;
    logic [MEM_DEPTH-1:0] valid_reg, valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    res_t                 m_res_reg, res_cmt;

    logic [WORD_W-1:0]    mem [MEM_DEPTH];
    logic [WORD_W-1:0]    rdata_reg, rd_word, word_reg, inval_reg, mem_wdata;
    logic                 rd_ok_reg, restart_reg;
    logic [ADDR_W-1:0]    mem_addr;
    logic [IDX_W-1:0]     mem_idx;
    logic                 mem_re, mem_we, mem_hit;

    logic [1:0]           s_op;
    logic [ADDR_W-1:0]    s_ld_addr;
    logic [WORD_W-1:0]    s_ld_data, s_in_val;
    logic                 accept, accept_exec, commit_fire, jump, advance;
    logic [OPC_W-1:0]     f_code, x_code;
    logic [ADDR_W-1:0]    f_addr, x_addr;

    assign s_op      = s_tuser;
    assign s_ld_addr = s_tdata[ADDR_W-1:0];
    assign s_ld_data = s_tdata[ADDR_W+WORD_W-1:ADDR_W];
    assign s_in_val  = s_tdata[ADDR_W+2*WORD_W-1:ADDR_W+WORD_W];

    // Words never written since reset, and addresses past the store, read as zero.
    assign rd_word = rd_ok_reg ? rdata_reg : '0;
    assign f_code  = rd_word[WORD_W-1:ADDR_W];
    assign f_addr  = rd_word[ADDR_W-1:0];
    assign x_code  = word_reg[WORD_W-1:ADDR_W];
    assign x_addr  = word_reg[ADDR_W-1:0];

    assign commit_fire = ((state_reg == ST_IMM) || (state_reg == ST_EXEC)) &&
                         (!m_tvalid_reg || m_tready);
    assign s_tready    = (state_reg == ST_IDLE) || commit_fire;
    assign accept      = s_tvalid && s_tready;

    // Commit of the item in flight.
    always_comb begin
        pc_cmt      = pc_reg;
        acc_cmt     = acc_reg;
        stopped_cmt = stopped_reg;
        jump        = 1'b0;
        advance     = 1'b0;
        res_cmt     = '0;
        if (state_reg == ST_IMM) begin
            if (restart_reg) begin
                pc_cmt      = '0;
                acc_cmt     = '0;
                stopped_cmt = 1'b0;
            end
        end else begin
            advance = 1'b1;
            case (x_code)
                OP_HLT: begin
                    stopped_cmt = 1'b1;
                    advance     = 1'b0;
                end
                OP_LDA: acc_cmt = rd_word;
                OP_JPA: jump = 1'b1;
                OP_JPZ: jump = (acc_reg == '0);
                OP_JPP: jump = !acc_reg[WORD_W-1];
                OP_ADD: acc_cmt = acc_reg + rd_word;
                OP_SUB: acc_cmt = acc_reg - rd_word;
                OP_OUT: begin
                    res_cmt.out_valid = 1'b1;
                    res_cmt.out_value = acc_reg;
                end
                OP_INP: begin
                    res_cmt.input_taken = 1'b1;
                    acc_cmt             = inval_reg;
                end
                default: ;
            endcase
            if (jump) begin
                pc_cmt = x_addr;
            end else if (advance) begin
                pc_cmt = pc_reg + ADDR_W'(1);
            end
        end
        res_cmt.halted  = stopped_cmt;
        res_cmt.pc_now  = pc_cmt;
        res_cmt.acc_now = acc_cmt;
    end

    // The architectural state seen by a beat accepted at this edge.
    assign pc_next      = commit_fire ? pc_cmt : pc_reg;
    assign acc_next     = commit_fire ? acc_cmt : acc_reg;
    assign stopped_next = commit_fire ? stopped_cmt : stopped_reg;
    assign accept_exec  = accept && (s_op == ITEM_STEP) && !stopped_next;

    // Store port: fetch or load at the accept edge, operand access in ST_FETCH.
    always_comb begin
        mem_addr  = pc_next;
        mem_wdata = s_ld_data;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        if (accept) begin
            if (accept_exec) begin
                mem_re = 1'b1;
            end else if (s_op == ITEM_LOAD) begin
                mem_we   = 1'b1;
                mem_addr = s_ld_addr;
            end
        end else if (state_reg == ST_FETCH) begin
            mem_addr  = f_addr;
            mem_wdata = acc_reg;
            case (f_code)
                OP_LDA, OP_ADD, OP_SUB: mem_re = 1'b1;
                OP_STO:                 mem_we = 1'b1;
                default: ;
            endcase
        end
    end

    assign mem_hit = {1'b0, mem_addr} < DEPTH_LIM;
    assign mem_idx = mem_addr[IDX_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        if (mem_we && mem_hit) begin
            valid_next[mem_idx] = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH: state_next = ST_EXEC;
            default: begin
                if (accept) begin
                    state_next = accept_exec ? ST_FETCH : ST_IMM;
                end else if (commit_fire) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign m_tvalid_next = commit_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            acc_reg      <= '0;
            stopped_reg  <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            acc_reg      <= acc_next;
            stopped_reg  <= stopped_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_fire) begin
            m_res_reg <= res_cmt;
        end
        if (state_reg == ST_FETCH) begin
            word_reg <= rd_word;
        end
        if (accept) begin
            inval_reg   <= s_in_val;
            restart_reg <= (s_op == ITEM_RESTART);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we && mem_hit) begin
            mem[mem_idx] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_idx];
            rd_ok_reg <= mem_hit && valid_reg[mem_idx];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(res_t))'(0), m_res_reg};

    // The store has a single port.
    assert property (@(posedge aclk) disable iff (!aresetn) !(mem_re && mem_we))
        else $error("store read and write in the same cycle");

    // An operand access always leads straight to the commit stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |=> state_reg == ST_EXEC)
        else $error("fetch not followed by execute");

    // The halt flag only changes when an item commits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !commit_fire |=> $stable(stopped_reg))
        else $error("halt flag changed outside a commit");

    // No beat both emits and takes a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_res_reg.out_valid && m_res_reg.input_taken))
        else $error("result both emits and takes a value");

endmodule
